// ----- src/ddf_pkg.sv -----
// shared constants, tables and types of the decimal digit formatter
package ddf_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 4;
    localparam int MODE_W     = 2;
    localparam int CODE_W     = 16;
    localparam int IDX_W      = 4;
    localparam int MAGIC_W    = 33;
    localparam int PROD_W     = VAL_W + MAGIC_W;
    localparam int SHIFT_W    = 5;

    localparam logic [CODE_W-1:0] CODE_ZERO     = 16'h00A2;
    localparam logic [CODE_W-1:0] CODE_OVERFLOW = 16'h00E2;
    localparam logic [CODE_W-1:0] CODE_PAD      = 16'h0001;
    localparam logic [CODE_W-1:0] CODE_END      = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_SPACE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd2;

    localparam logic [VAL_W-1:0] POW [MAX_DIGITS] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000,
        32'd100000, 32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    // ceil(log2(10^k)), exact reciprocal shift
    localparam logic [SHIFT_W-1:0] SHIFT [MAX_DIGITS] = '{
        5'd0, 5'd4, 5'd7, 5'd10, 5'd14, 5'd17, 5'd20, 5'd24, 5'd27, 5'd30
    };

    // ceil(2^(32+s) / 10^k)
    localparam logic [MAGIC_W-1:0] MAGIC [MAX_DIGITS] = '{
        33'(((66'd1 << 32) + 66'd1 - 66'd1) / 66'd1),
        33'(((66'd1 << 36) + 66'd10 - 66'd1) / 66'd10),
        33'(((66'd1 << 39) + 66'd100 - 66'd1) / 66'd100),
        33'(((66'd1 << 42) + 66'd1000 - 66'd1) / 66'd1000),
        33'(((66'd1 << 46) + 66'd10000 - 66'd1) / 66'd10000),
        33'(((66'd1 << 49) + 66'd100000 - 66'd1) / 66'd100000),
        33'(((66'd1 << 52) + 66'd1000000 - 66'd1) / 66'd1000000),
        33'(((66'd1 << 56) + 66'd10000000 - 66'd1) / 66'd10000000),
        33'(((66'd1 << 59) + 66'd100000000 - 66'd1) / 66'd100000000),
        33'(((66'd1 << 62) + 66'd1000000000 - 66'd1) / 66'd1000000000)
    };

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] top_idx;
        logic             show;
        logic             space;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT,
        ST_TERM
    } t_state;

endpackage

// ----- src/ddf_front.sv -----
// input stage: accepts requests, clamps the digit count and decodes the pad mode
module ddf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ddf_pkg::VAL_W-1:0]  i_value,
    input  logic [ddf_pkg::CNT_W-1:0]  i_digit_count,
    input  logic [ddf_pkg::MODE_W-1:0] i_pad_mode,
    output logic                       o_cmd_valid,
    input  logic                       i_cmd_ready,
    output ddf_pkg::t_cmd              o_cmd
);
    import ddf_pkg::*;

    logic          r_valid;
    t_cmd          r_cmd;
    t_cmd          n_cmd;
    logic [CNT_W-1:0] cnt;

    always_comb begin
        cnt = i_digit_count;
        if (cnt == '0) begin
            cnt = CNT_W'(1);
        end else if (cnt > CNT_W'(MAX_DIGITS)) begin
            cnt = CNT_W'(MAX_DIGITS);
        end
        n_cmd.value   = i_value;
        n_cmd.top_idx = IDX_W'(cnt - CNT_W'(1));
        n_cmd.show    = (i_pad_mode == MODE_ZERO);
        n_cmd.space   = (i_pad_mode == MODE_SPACE);
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- src/ddf_queue.sv -----
// two-entry request queue between the input stage and the digit engine
module ddf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ddf_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output ddf_pkg::t_cmd o_pop_cmd
);
    import ddf_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- src/ddf_back.sv -----
// digit engine: reciprocal multiply per position, output register
module ddf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_pop,
    input  ddf_pkg::t_cmd              i_cmd,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ddf_pkg::CODE_W-1:0] o_char_code,
    output logic                       o_last
);
    import ddf_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [VAL_W-1:0]    r_val;
    logic [IDX_W-1:0]    r_idx;
    logic                r_show;
    logic                r_space;
    logic [PROD_W-1:0]   r_prod;
    logic                r_ov;
    logic [CODE_W-1:0]   r_code;
    logic                r_last;

    logic                out_free;
    logic [PROD_W-1:0]   q_full;
    logic [CODE_W-1:0]   digit;
    logic [47:0]         back_prod;
    logic [VAL_W-1:0]    rest;
    logic                show_now;
    logic                want_out;
    logic [CODE_W-1:0]   digit_code;
    logic                load;
    logic                step;
    logic                emit;
    logic [CODE_W-1:0]   emit_code;
    logic                emit_last;

    assign out_free   = !r_ov || i_ready;
    assign q_full     = r_prod >> (7'd32 + 7'(SHIFT[r_idx]));
    assign digit      = q_full[CODE_W-1:0];
    assign back_prod  = 48'(POW[r_idx]) * 48'(digit);
    assign rest       = r_val - back_prod[VAL_W-1:0];
    assign show_now   = r_show || (digit != '0) || (r_idx == '0);
    assign want_out   = show_now || r_space;
    assign digit_code = (digit >= CODE_W'(10)) ? CODE_OVERFLOW : CODE_ZERO + digit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!want_out || out_free) begin
                    n_state = (r_idx == '0) ? ST_TERM : ST_MUL;
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        load      = 1'b0;
        step      = 1'b0;
        emit      = 1'b0;
        emit_code = CODE_END;
        emit_last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                load = i_cmd_valid;
            end
            ST_MUL: begin
            end
            ST_EMIT: begin
                step      = !want_out || out_free;
                emit      = want_out && out_free;
                emit_code = show_now ? digit_code : CODE_PAD;
            end
            ST_TERM: begin
                emit      = out_free;
                emit_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_cmd_pop   = load;
    assign o_valid     = r_ov;
    assign o_char_code = r_code;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val   <= i_cmd.value;
            r_idx   <= i_cmd.top_idx;
            r_show  <= i_cmd.show;
            r_space <= i_cmd.space;
        end else if (step) begin
            r_val  <= rest;
            r_show <= show_now;
            r_idx  <= r_idx - IDX_W'(1);
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_val) * PROD_W'(MAGIC[r_idx]);
        end
        if (emit) begin
            r_code <= emit_code;
            r_last <= emit_last;
        end
    end

`ifndef SYNTHESIS
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last) |-> (r_code == CODE_END))
        else $error("tlast without terminator code");

    a_end_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_last) |-> (r_code != CODE_END))
        else $error("terminator code without tlast");

    a_mul_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_EMIT))
        else $error("multiply step not followed by emit step");
`endif

endmodule

// ----- src/decimal_digit_formatter.sv -----
// decimal digit formatter top level: input stage, request queue, digit engine
// a request is registered in the input stage, then queued and loaded by the engine;
//   the engine serves one request at a time in its multiply-then-reduce loop, with a
//   multiply step and an emit step per position, then the terminator from its own state
// the input stage and the two-entry queue take new requests while the engine works
// reset: synchronous active-low i_rst_n empties the queue and idles the engine
module decimal_digit_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // value[31:0], digit_count[35:32], pad_mode[37:36]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // char_code[15:0]
    output logic        o_m_axis_tlast
);
    import ddf_pkg::*;

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    ddf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_value       (i_s_axis_tdata[31:0]),
        .i_digit_count (i_s_axis_tdata[35:32]),
        .i_pad_mode    (i_s_axis_tdata[37:36]),
        .o_cmd_valid   (f_valid),
        .i_cmd_ready   (f_ready),
        .o_cmd         (f_cmd)
    );

    ddf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_cmd    (q_cmd)
    );

    ddf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_cmd       (q_cmd),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char_code (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule
